// ===== design/png_scanline_unfilter_defines.svh =====
// Assertion helpers for the top-level design file.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psu_pkg.sv =====
package psu_pkg;

  // Sizes
  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int COL_W           = $clog2(MAX_ROW_BYTES);
  localparam int SLOT_W          = $clog2(MAX_PIXEL_BYTES);
  localparam int BPP_W           = 4;
  localparam int RB_W            = 14;
  localparam int RC_W            = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BPP       = 2'd0;
  localparam cfg_idx_t CFG_ROW_BYTES = 2'd1;
  localparam cfg_idx_t CFG_ROW_COUNT = 2'd2;

  // PNG filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // Remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // One data byte (or the error transaction) waiting for reconstruction
  typedef struct packed {
    logic              is_err;
    logic [7:0]        x;
    filt_t             filt;
    logic [SLOT_W-1:0] slot;
    logic              past;
    logic              first;
    logic              row_last;
    logic              image_last;
    logic [COL_W-1:0]  col;
  } s1_t;

  // bytes_per_pixel as used: 0 acts as 1, large values saturate
  function automatic logic [BPP_W-1:0] bpp_clamp(input logic [BPP_W-1:0] v);
    logic [BPP_W-1:0] r;
    if (v == '0) begin
      r = BPP_W'(1);
    end else if (v > BPP_W'(MAX_PIXEL_BYTES)) begin
      r = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/psu_in_if.sv =====
interface psu_in_if import psu_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== design/psu_out_if.sv =====
interface psu_out_if import psu_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       row_end;
  logic       image_end;
  logic       bad_filter;

  modport source (output valid, output out_byte, output row_end, output image_end,
                  output bad_filter, input ready);
  modport sink   (input valid, input out_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

// ===== design/psu_cfg_if.sv =====
interface psu_cfg_if import psu_pkg::*;;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/psu_slot_div.sv =====
// Restoring remainder, one dividend bit per cycle: column mod bytes_per_pixel
module psu_slot_div import psu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [COL_W-1:0]  dividend,
  input  logic [BPP_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [SLOT_W-1:0] rem
);

  localparam int CNT_W = $clog2(COL_W + 1);

  logic [COL_W-1:0] dvd_r;
  logic [BPP_W-1:0] dvs_r;
  logic [BPP_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [BPP_W-1:0] trial;
  logic [BPP_W-1:0] rem_step;

  // One shift-subtract step
  always_comb begin
    trial    = {rem_r[BPP_W-2:0], dvd_r[COL_W-1]};
    rem_step = (trial >= dvs_r) ? trial - dvs_r : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dvd_r  <= '0;
      dvs_r  <= BPP_W'(1);
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(COL_W);
      rem_r  <= '0;
      dvd_r  <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[COL_W-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r[SLOT_W-1:0];

endmodule

// ===== design/psu_predict.sv =====
// Filter predictor and byte reconstruction
module psu_predict import psu_pkg::*; (
  input  filt_t      filt,
  input  logic [7:0] x,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] c,
  output logic [7:0] raw
);

  // Paeth predictor without signed arithmetic
  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic [8:0] s_ab;
    logic [8:0] s_cc;
    logic [8:0] pa;
    logic [8:0] pb;
    logic [8:0] pc;
    logic [7:0] r;
    s_ab = {1'b0, pa_a} + {1'b0, pa_b};
    s_cc = {pa_c, 1'b0};
    pa   = (pa_b > pa_c) ? {1'b0, pa_b - pa_c} : {1'b0, pa_c - pa_b};
    pb   = (pa_a > pa_c) ? {1'b0, pa_a - pa_c} : {1'b0, pa_c - pa_a};
    pc   = (s_ab > s_cc) ? s_ab - s_cc : s_cc - s_ab;
    if (pa <= pb && pa <= pc) begin
      r = pa_a;
    end else if (pb <= pc) begin
      r = pa_b;
    end else begin
      r = pa_c;
    end
    return r;
  endfunction

  logic [8:0] avg_sum;
  logic [7:0] pred;

  always_comb begin
    avg_sum = {1'b0, a} + {1'b0, b};
    case (filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
  end

  assign raw = x + pred;

endmodule

// ===== design/png_scanline_unfilter.sv =====
// A data byte passes a stage register, then a result register, before it is offered as a
// result; type bytes give none. Throughput: one byte per cycle while the output accepts
// and no remainder run is under way, set by the single line-buffer read per byte and the
// output register. Writing bytes_per_pixel recomputes the pixel slot of the current column,
// and the input is held off during the 13 remainder steps and while the result is loaded.
// Reset clears control state and pixel history; the line buffer is not cleared.
module png_scanline_unfilter import psu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  psu_in_if.sink          in_port,
  psu_out_if.source       out_port,
  psu_cfg_if.sink         cfg_port
);

`include "png_scanline_unfilter_defines.svh"

  // Configuration
  logic [BPP_W-1:0] bpp_r;
  logic [RB_W-1:0]  rb_r;
  logic [RC_W-1:0]  rc_r;
  logic [BPP_W-1:0] bpp_eff;
  logic [RB_W-1:0]  rb_eff;
  logic [RC_W-1:0]  rc_eff;
  logic             cfg_fire;

  // Row tracking
  logic [COL_W-1:0]  column_r, column_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [RC_W-1:0]   row_index_r, row_index_nxt;
  filt_t             filt_r, filt_nxt;
  logic              await_r, await_nxt;
  logic              error_hold_r, error_hold_nxt;

  // Stage and output registers
  s1_t        s1_r, s1_nxt;
  logic       s1_v_r, s1_v_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_row_end_r;
  logic       out_image_end_r;
  logic       out_bad_r;

  // Line buffer and pixel history
  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rd_r;
  logic [7:0] left_r [MAX_PIXEL_BYTES];
  logic [7:0] ul_r   [MAX_PIXEL_BYTES];

  // Remainder unit
  div_stat_t         div_stat;
  logic [SLOT_W-1:0] div_rem;
  logic              div_start;

  logic             in_ready;
  logic             in_fire;
  logic             s1_go;
  logic             s1_load;
  logic             rd_en;
  logic [RB_W-1:0]  col_inc;
  logic [RC_W:0]    row_inc;
  logic             row_last;
  logic             image_last;
  logic             past;
  logic             slot_wrap;
  logic [7:0]       a_val, b_val, c_val, raw;

  // Effective register values
  always_comb begin
    bpp_eff = bpp_clamp(bpp_r);
    if (rb_r == '0) begin
      rb_eff = RB_W'(1);
    end else if (rb_r > RB_W'(MAX_ROW_BYTES)) begin
      rb_eff = RB_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_r;
    end
    rc_eff = (rc_r == '0) ? RC_W'(1) : rc_r;
  end

  // Configuration writes
  assign cfg_port.ready = 1'b1;
  assign cfg_fire  = cfg_port.valid;
  assign div_start = cfg_fire && (cfg_port.index == CFG_BPP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_W'(1);
      rb_r  <= RB_W'(1);
      rc_r  <= RC_W'(1);
    end else if (cfg_fire) begin
      case (cfg_port.index)
        CFG_BPP:       bpp_r <= cfg_port.data[BPP_W-1:0];
        CFG_ROW_BYTES: rb_r  <= cfg_port.data[RB_W-1:0];
        CFG_ROW_COUNT: rc_r  <= cfg_port.data[RC_W-1:0];
        default:       ;
      endcase
    end
  end

  psu_slot_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (column_r),
    .divisor  (bpp_clamp(cfg_port.data[BPP_W-1:0])),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  // Handshake
  assign s1_go    = s1_v_r && (!out_valid_r || out_port.ready);
  assign in_ready = !div_stat.busy && !div_stat.done && (!s1_v_r || s1_go);
  assign in_fire  = in_port.valid && in_ready;
  assign in_port.ready = in_ready;

  // Position of the incoming byte
  always_comb begin
    col_inc    = RB_W'(column_r) + RB_W'(1);
    row_inc    = (RC_W+1)'(row_index_r) + (RC_W+1)'(1);
    row_last   = (col_inc >= rb_eff);
    image_last = row_last && (row_inc >= (RC_W+1)'(rc_eff));
    past       = (column_r >= COL_W'(bpp_eff));
    slot_wrap  = (BPP_W'(slot_r) == bpp_eff - BPP_W'(1));
  end

  // Front end: classify the transaction and advance the row position
  always_comb begin
    column_nxt     = column_r;
    slot_nxt       = slot_r;
    row_index_nxt  = row_index_r;
    filt_nxt       = filt_r;
    await_nxt      = await_r;
    error_hold_nxt = error_hold_r;
    s1_load        = 1'b0;
    rd_en          = 1'b0;
    s1_nxt         = s1_r;

    if (div_stat.done) begin
      slot_nxt = div_rem;
    end

    if (in_fire && !error_hold_r) begin
      if (await_r) begin
        if (in_port.in_byte > 8'(FILT_PAETH)) begin
          // Bad filter type: one error transaction, then drop everything
          error_hold_nxt    = 1'b1;
          s1_load           = 1'b1;
          s1_nxt            = '0;
          s1_nxt.is_err     = 1'b1;
        end else begin
          filt_nxt   = filt_t'(in_port.in_byte[2:0]);
          await_nxt  = 1'b0;
          column_nxt = '0;
          slot_nxt   = '0;
        end
      end else begin
        s1_load           = 1'b1;
        rd_en             = 1'b1;
        s1_nxt.is_err     = 1'b0;
        s1_nxt.x          = in_port.in_byte;
        s1_nxt.filt       = filt_r;
        s1_nxt.slot       = slot_r;
        s1_nxt.past       = past;
        s1_nxt.first      = (row_index_r == '0);
        s1_nxt.row_last   = row_last;
        s1_nxt.image_last = image_last;
        s1_nxt.col        = column_r;
        if (row_last) begin
          await_nxt     = 1'b1;
          column_nxt    = '0;
          slot_nxt      = '0;
          row_index_nxt = image_last ? '0 : row_index_r + RC_W'(1);
        end else begin
          column_nxt = column_r + COL_W'(1);
          slot_nxt   = slot_wrap ? '0 : slot_r + SLOT_W'(1);
        end
      end
    end
  end

  // Neighbor bytes for the staged byte
  always_comb begin
    b_val = s1_r.first ? 8'd0 : rd_r;
    a_val = s1_r.past ? left_r[s1_r.slot] : 8'd0;
    c_val = (s1_r.past && !s1_r.first) ? ul_r[s1_r.slot] : 8'd0;
  end

  psu_predict u_pred (
    .filt (s1_r.filt),
    .x    (s1_r.x),
    .a    (a_val),
    .b    (b_val),
    .c    (c_val),
    .raw  (raw)
  );

  // Valid flags
  always_comb begin
    s1_v_nxt      = s1_load ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    out_valid_nxt = s1_go ? 1'b1 : ((out_valid_r && out_port.ready) ? 1'b0 : out_valid_r);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      slot_r       <= '0;
      row_index_r  <= '0;
      filt_r       <= FILT_NONE;
      await_r      <= 1'b1;
      error_hold_r <= 1'b0;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      column_r     <= column_nxt;
      slot_r       <= slot_nxt;
      row_index_r  <= row_index_nxt;
      filt_r       <= filt_nxt;
      await_r      <= await_nxt;
      error_hold_r <= error_hold_nxt;
      s1_v_r       <= s1_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Staged transaction payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_byte_r      <= s1_r.is_err ? 8'd0 : raw;
      out_row_end_r   <= !s1_r.is_err && s1_r.row_last;
      out_image_end_r <= !s1_r.is_err && s1_r.image_last;
      out_bad_r       <= s1_r.is_err;
    end
  end

  // Pixel history, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= 8'd0;
        ul_r[i]   <= 8'd0;
      end
    end else if (s1_go && !s1_r.is_err) begin
      left_r[s1_r.slot] <= raw;
      ul_r[s1_r.slot]   <= b_val;
    end
  end

  // Line buffer: read at accept, write when the byte leaves the stage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[column_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_r.is_err) begin
      mem[s1_r.col] <= raw;
    end
  end

  assign out_port.valid      = out_valid_r;
  assign out_port.out_byte   = out_byte_r;
  assign out_port.row_end    = out_row_end_r;
  assign out_port.image_end  = out_image_end_r;
  assign out_port.bad_filter = out_bad_r;

  // Checks
  `PSU_ASSERT_IMP(a_err_alone, error_hold_r && s1_v_r, s1_r.is_err,
                  "data byte staged after a bad filter type")
  `PSU_ASSERT_IMP(a_slot_range, !div_stat.busy && !div_stat.done,
                  BPP_W'(slot_r) < bpp_eff, "pixel slot out of range")
  `PSU_ASSERT_IMP(a_image_row, out_valid_r && out_image_end_r, out_row_end_r,
                  "image end without row end")

endmodule

// ===== tb/png_scanline_unfilter_checker.sv =====
module png_scanline_unfilter_checker import psu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  psu_in_if           in_ch,
  psu_out_if          out_ch,
  psu_cfg_if          cfg_ch,
  output int unsigned pending,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // One reconstructed byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } raw_byte_t;

  raw_byte_t raw_q[$];
  int unsigned errs = 0;

  // Register copies, raw as written
  logic [BPP_W-1:0] reg_bpp;
  logic [RB_W-1:0]  reg_rb;
  logic [RC_W-1:0]  reg_rc;

  // Unfilter state
  logic [7:0]  line_buf [MAX_ROW_BYTES];
  logic [7:0]  left_hist [MAX_PIXEL_BYTES];
  logic [7:0]  ul_hist [MAX_PIXEL_BYTES];
  int unsigned col;
  int unsigned row_idx;
  filt_t       cur_filt;
  bit          await_filt;
  bit          err_hold;

  function automatic int paeth_pick(input int a, input int b, input int c);
    int pa, pb, pc;
    pa = (b > c) ? b - c : c - b;
    pb = (a > c) ? a - c : c - a;
    pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Advances the unfilter state by one stream byte; returns 1 when a byte comes out
  function automatic bit unfilter_byte(input logic [7:0] x, output raw_byte_t res);
    int unsigned bpp, rb, rc, slot;
    int a, b, c, pred;
    logic [7:0] raw;
    bit first_row, row_last, image_last;
    res = '0;
    if (err_hold) return 1'b0;

    // Row start: filter type, or the error transaction
    if (await_filt) begin
      if (x > 8'(FILT_PAETH)) begin
        err_hold = 1'b1;
        res.bad_filter = 1'b1;
        return 1'b1;
      end
      cur_filt = filt_t'(x[2:0]);
      await_filt = 1'b0;
      col = 0;
      return 1'b0;
    end

    // Registers as used
    bpp = (reg_bpp == '0) ? 1 : (reg_bpp > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : reg_bpp;
    rb = (reg_rb == '0) ? 1 : (reg_rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : reg_rb;
    rc = (reg_rc == '0) ? 1 : reg_rc;

    if (col >= MAX_ROW_BYTES) col = MAX_ROW_BYTES - 1;
    slot = col % bpp;
    first_row = (row_idx == 0);

    // Neighbors: above is zero on the first row, left and upper-left before one pixel
    b = first_row ? 0 : line_buf[col];
    if (col >= bpp) begin
      a = left_hist[slot];
      c = first_row ? 0 : ul_hist[slot];
    end else begin
      a = 0;
      c = 0;
    end

    case (cur_filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) >> 1;
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 0;
    endcase
    raw = 8'(int'(x) + pred);

    ul_hist[slot] = 8'(b);
    left_hist[slot] = raw;
    line_buf[col] = raw;

    // Row and image position
    row_last = (col + 1 >= rb);
    image_last = row_last && (row_idx + 1 >= rc);
    if (row_last) begin
      await_filt = 1'b1;
      col = 0;
      row_idx = image_last ? 0 : ((row_idx + 1) & 16'hFFFF);
    end else begin
      col++;
    end

    res.data = raw;
    res.row_end = row_last;
    res.image_end = image_last;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errs++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endtask

  // Watch all three channels at each edge; results first, then new transactions
  always @(posedge clk) begin
    raw_byte_t want, made;
    if (!rst_n) begin
      reg_bpp = BPP_W'(1);
      reg_rb = RB_W'(1);
      reg_rc = RC_W'(1);
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i] = '0;
        ul_hist[i] = '0;
      end
      col = 0;
      row_idx = 0;
      cur_filt = FILT_NONE;
      await_filt = 1'b1;
      err_hold = 1'b0;
      raw_q.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (raw_q.size() == 0) begin
          errs++;
          $error("result transaction with nothing expected: out_byte %0h", out_ch.out_byte);
        end else begin
          want = raw_q.pop_front();
          check_field("out_byte", want.data, out_ch.out_byte);
          check_field("row_end", 8'(want.row_end), 8'(out_ch.row_end));
          check_field("image_end", 8'(want.image_end), 8'(out_ch.image_end));
          check_field("bad_filter", 8'(want.bad_filter), 8'(out_ch.bad_filter));
        end
      end

      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          CFG_BPP:       reg_bpp = cfg_ch.data[BPP_W-1:0];
          CFG_ROW_BYTES: reg_rb = cfg_ch.data[RB_W-1:0];
          CFG_ROW_COUNT: reg_rc = cfg_ch.data[RC_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        if (unfilter_byte(in_ch.in_byte, made)) raw_q.push_back(made);
      end
    end
    pending <= raw_q.size();
    fail_count <= errs;
  end

endmodule

// ===== tb/png_scanline_unfilter_tb.sv =====
module png_scanline_unfilter_tb import psu_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_PATTERN} rx_mode_t;

  // Five rows of three bytes, bpp 2: Paeth on the first row, then every filter
  localparam logic [7:0] DIRECTED_ROWS [20] = '{
    8'(FILT_PAETH), 8'h00, 8'hFF, 8'h80,
    8'(FILT_NONE),  8'h7F, 8'h01, 8'hFE,
    8'(FILT_SUB),   8'h55, 8'hAA, 8'h01,
    8'(FILT_UP),    8'hFF, 8'hFF, 8'h00,
    8'(FILT_AVG),   8'h80, 8'h7F, 8'hFF
  };

  logic clk;
  logic rst_n;

  psu_in_if  in_ch ();
  psu_out_if out_ch ();
  psu_cfg_if cfg_ch ();

  int unsigned pending;
  int unsigned fail_count;
  int unsigned hold_req = 0;

  // Stream position, kept to build whole rows and images
  int unsigned eff_rb = 1;
  int unsigned eff_rc = 1;
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;
  bit          pos_await = 1'b1;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  png_scanline_unfilter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch),
    .cfg_port (cfg_ch)
  );

  png_scanline_unfilter_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: the stall mode is redrawn at random, plus one long hold
  initial begin
    int unsigned seg_left, hold_left, hold_taken, tick;
    rx_mode_t mode;
    seg_left = 0;
    hold_left = 0;
    hold_taken = 0;
    tick = 0;
    mode = RX_ALWAYS;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_taken != hold_req) begin
        hold_taken = hold_req;
        hold_left = 300;
      end
      if (seg_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(16, 256);
      end
      seg_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
          default:   out_ch.ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  // Random register word; upper bits beyond the register width are noise
  function automatic logic [CFG_DATA_W-1:0] rand_cfg(input cfg_idx_t idx);
    int unsigned roll;
    logic [CFG_DATA_W-1:0] w;
    roll = $urandom_range(0, 9);
    w = CFG_DATA_W'($urandom);
    case (idx)
      CFG_BPP:
        w[BPP_W-1:0] = (roll < 8) ? BPP_W'($urandom_range(1, 8)) :
                       (roll == 8) ? BPP_W'(0) : BPP_W'($urandom_range(9, 15));
      CFG_ROW_BYTES:
        w[RB_W-1:0] = (roll < 7) ? RB_W'($urandom_range(1, 24)) :
                      (roll < 9) ? RB_W'($urandom_range(25, 96)) : RB_W'(0);
      default:
        w = (roll < 8) ? CFG_DATA_W'($urandom_range(1, 5)) : '0;
    endcase
    return w;
  endfunction

  // One input transaction, with burst gaps, then the position update
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
                   $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (pos_await) begin
      pos_await = 1'b0;
      pos_col = 0;
    end else if (pos_col + 1 >= eff_rb) begin
      pos_await = 1'b1;
      pos_col = 0;
      pos_row = (pos_row + 1 >= eff_rc) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  // Filter type at a row start, data otherwise
  task automatic send_next();
    if (pos_await) send_byte(8'($urandom_range(0, 4)));
    else send_byte(8'($urandom));
  endtask

  task automatic run_to_image_start();
    while (!(pos_await && pos_row == 0)) send_next();
  endtask

  task automatic send_image();
    send_next();
    run_to_image_start();
  endtask

  // Idle until every expected byte has left, with a margin for a trailing type byte
  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_idle(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_ROW_BYTES: begin
        eff_rb = value[RB_W-1:0];
        if (eff_rb == 0) eff_rb = 1;
        else if (eff_rb > MAX_ROW_BYTES) eff_rb = MAX_ROW_BYTES;
      end
      CFG_ROW_COUNT: eff_rc = (value == '0) ? 1 : value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] bpp_w,
                           input logic [CFG_DATA_W-1:0] rb_w,
                           input logic [CFG_DATA_W-1:0] rc_w);
    write_idle(CFG_BPP, bpp_w);
    write_idle(CFG_ROW_BYTES, rb_w);
    write_idle(CFG_ROW_COUNT, rc_w);
  endtask

  initial begin
    int unsigned target;
    cfg_idx_t pick;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_BPP;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: one-byte rows, one-row images
    send_byte(8'(FILT_NONE));
    send_byte(8'hFF);

    // Every filter over a small image with extreme bytes
    configure(16'd2, 16'd3, 16'd5);
    foreach (DIRECTED_ROWS[i]) send_byte(DIRECTED_ROWS[i]);

    // Output held off while the input keeps offering: the block must back up
    configure(rand_cfg(CFG_BPP), 16'd40, 16'd4);
    hold_req <= hold_req + 1;
    send_image();

    // Widest row: out-of-range row_bytes saturates, bpp write carries noise bits;
    // the first row is then cut short by shrinking row_bytes
    configure(16'hFFF8, 16'hFFFF, 16'd2);
    repeat (41) send_next();
    write_idle(CFG_ROW_BYTES, 16'd24);
    run_to_image_start();

    // Tallest image cut short: row_count dropped to zero after three rows
    configure(rand_cfg(CFG_BPP), 16'($urandom_range(1, 6)), 16'hFFFF);
    repeat (3) begin
      send_next();
      while (!pos_await) send_next();
    end
    write_idle(CFG_ROW_COUNT, 16'd0);
    run_to_image_start();

    // Random images, some with a register changed mid-image
    target = items_sent + 1550;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        configure(rand_cfg(CFG_BPP), rand_cfg(CFG_ROW_BYTES), rand_cfg(CFG_ROW_COUNT));
        repeat ($urandom_range(1, 2)) send_image();
      end else begin
        configure(rand_cfg(CFG_BPP), 16'($urandom_range(2, 30)), 16'($urandom_range(2, 6)));
        repeat ($urandom_range(1, eff_rb * eff_rc)) send_next();
        pick = cfg_idx_t'($urandom_range(0, 2));
        // row_bytes may only shrink within an image: the line buffer holds no more
        if (pick == CFG_ROW_BYTES) write_idle(pick, 16'($urandom_range(1, eff_rb)));
        else write_idle(pick, rand_cfg(pick));
        run_to_image_start();
      end
    end

    // Bad filter type ends everything; following bytes are swallowed
    settle();
    send_byte(8'($urandom_range(5, 255)));
    repeat (6) send_byte(8'($urandom));
    settle();
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
